### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/oca_pkg.sv
package oca_pkg;

  localparam int WIDTH = 16;
  localparam int MAG_W = WIDTH - 1;
  localparam int PROD_W = 2 * MAG_W;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic              neg;
    logic              dz;
    logic              add_ovf;
    logic [WIDTH-1:0]  add_res;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  rem;
    logic [MAG_W-1:0]  quo;
    logic [MAG_W-1:0]  dsr;
  } item_t;

  function automatic logic [MAG_W-1:0] magnitude(input logic [WIDTH-1:0] x);
    magnitude = x[WIDTH-1] ? ~x[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] encode(input logic neg, input logic [MAG_W-1:0] mag);
    logic [WIDTH-1:0] full;
    full = {1'b0, mag};
    if (mag == '0) begin
      encode = '0;
    end else if (neg) begin
      encode = ~full;
    end else begin
      encode = full;
    end
  endfunction

endpackage

### rtl/oca_div_stage.sv
module oca_div_stage
  import oca_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             fits;
  item_t            item_next;

  // one restoring division step: shift in the next dividend bit, try the divisor
  always_comb begin
    trial = {in_item.rem, in_item.quo[MAG_W-1]};
    diff  = trial - {1'b0, in_item.dsr};
    fits  = trial >= {1'b0, in_item.dsr};
    item_next = in_item;
    item_next.rem = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    item_next.quo = {in_item.quo[MAG_W-2:0], fits};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

### rtl/ones_complement_alu_top.sv
// channel   | handshake            | word
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | op, operand_a, operand_b
// output    | out_valid / out_ready| result_bits, overflowed, divided_by_zero
//
// one word enters per cycle while in_ready is high, i.e. unless a full first stage is stalled
// each word passes the divider, one restoring step per stage, 15 stages,
// plus an operand stage (add, magnitudes, multiply) and the output register
// reset clears the valid bits only; no clearing pass
// each stage holds while the one after it is full and stalled; bubbles close up
module ones_complement_alu_top
  import oca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       op,
  input  logic [15:0]      operand_a,
  input  logic [15:0]      operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      result_bits,
  output logic             overflowed,
  output logic             divided_by_zero
);

  `include "assert_macros.svh"

  logic [MAG_W:0] v;
  logic [MAG_W:0] rdy;
  item_t          items [0:MAG_W];

  // operand stage
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] wrapped;
  logic [MAG_W-1:0] ma;
  logic [MAG_W-1:0] mb;
  item_t            s1_next;
  logic             s1_valid;
  item_t            s1_item;

  always_comb begin
    a       = operand_a[WIDTH-1:0];
    b       = operand_b[WIDTH-1:0];
    addend  = (op == OP_SUB) ? ~b : b;
    sum     = {1'b0, a} + {1'b0, addend};
    wrapped = sum[WIDTH-1:0] + {{(WIDTH-1){1'b0}}, sum[WIDTH]};
    ma      = magnitude(a);
    mb      = magnitude(b);
    s1_next.op      = op;
    s1_next.neg     = a[WIDTH-1] ^ b[WIDTH-1];
    s1_next.dz      = (op == OP_DIV) && (mb == '0);
    s1_next.add_ovf = (a[WIDTH-1] == addend[WIDTH-1]) && (wrapped[WIDTH-1] != a[WIDTH-1]);
    s1_next.add_res = wrapped;
    s1_next.prod    = ma * mb;
    s1_next.rem     = '0;
    s1_next.quo     = ma;
    s1_next.dsr     = mb;
  end

  assign in_ready = !s1_valid || rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= s1_next;
    end
  end

  assign v[0]     = s1_valid;
  assign items[0] = s1_item;

  // divider stages
  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    oca_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (rdy[k]),
      .in_item   (items[k]),
      .out_valid (v[k+1]),
      .out_ready (rdy[k+1]),
      .out_item  (items[k+1])
    );
  end

  // result encode and output register
  item_t            last;
  logic             mul_ovf;
  logic [MAG_W-1:0] mul_mag;
  logic [WIDTH-1:0] res_next;
  logic             ovf_next;
  logic             dz_next;

  always_comb begin
    last     = items[MAG_W];
    mul_ovf  = last.prod[PROD_W-1:MAG_W] != '0;
    mul_mag  = mul_ovf ? {MAG_W{1'b1}} : last.prod[MAG_W-1:0];
    res_next = '0;
    ovf_next = 1'b0;
    dz_next  = 1'b0;
    case (last.op)
      OP_ADD, OP_SUB: begin
        res_next = last.add_res;
        ovf_next = last.add_ovf;
      end
      OP_MUL: begin
        res_next = encode(last.neg, mul_mag);
        ovf_next = mul_ovf;
      end
      OP_DIV: begin
        res_next = last.dz ? '0 : encode(last.neg, last.quo);
        dz_next  = last.dz;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  assign rdy[MAG_W] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[MAG_W]) begin
      out_valid <= v[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[MAG_W] && v[MAG_W]) begin
      result_bits     <= res_next[15:0];
      overflowed      <= ovf_next;
      divided_by_zero <= dz_next;
    end
  end

  `ASSERT_NEXT(a_enter_stage, in_valid && in_ready, v[0])
  `ASSERT_ALWAYS(a_dz_only_div, !v[0] || !items[0].dz || items[0].op == OP_DIV)
  `ASSERT_ALWAYS(a_rem_below_dsr, !v[MAG_W] || last.dz || last.op != OP_DIV || last.rem < last.dsr)
  `ASSERT_ALWAYS(a_dz_clean, !out_valid || !divided_by_zero || (result_bits == '0 && !overflowed))

endmodule
